@@ rtl/wena_pkg.sv @@
// Shared types and constants of the weighted error norm accumulator.
`timescale 1ns / 1ps

package wena_pkg;

  // Norm mode codes held in the configuration register
  localparam logic [1:0] MODE_L1   = 2'd0;
  localparam logic [1:0] MODE_L2   = 2'd1;
  localparam logic [1:0] MODE_LINF = 2'd2;
  localparam logic [1:0] MODE_RST  = MODE_L2;

  // Root unit geometry: radicand of twice the root width
  localparam int ROOT_W = 33;
  localparam int RAD_W  = 2 * ROOT_W;

  // Accumulator width and its saturation ceiling
  localparam int          ACC_W   = 64;
  localparam logic [63:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // One mesh cell
  typedef struct packed {
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_z;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [31:0] est_z;
    logic [31:0]        cell_area;
    logic               last_cell;
  } in_item_t;

  // One result
  typedef struct packed {
    logic [31:0] cell_error;
    logic [62:0] norm_value;
    logic        norm_ready;
    logic        overflow;
  } out_item_t;

endpackage

@@ rtl/weighted_error_norm_accumulator.sv @@
// Top level: L1 / L2 / Linf error norm over a stream of mesh cells, L1 and L2 area-weighted.
//
//   channel  direction  handshake               beat
//   in       input      in_valid_i / in_stall_o  in_data_i  (in_item_t)
//   out      output     out_valid_o / out_stall_i out_data_o (out_item_t)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (norm mode)
//
// Each cell is squared component by component on the shared 32x32 multiplier, then
// the bit-serial root of the sum of squares is taken, one to five multiply and accumulate
// steps follow (Linf compares, L1 weights by area, L2 squares and weights) and the
// result is parked. The last cell of an L2 mesh also takes the final root of the sum.
// The input stalls from acceptance until the result is parked in the output register.
// Reset puts the mode at L2 and clears the accumulator and the overflow flag.
`timescale 1ns / 1ps

module weighted_error_norm_accumulator
  import wena_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  localparam int CwEff = (COMPONENT_WIDTH < 32) ? COMPONENT_WIDTH : 32;
  localparam int ExtW  = 33 - CwEff;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQR,
    S_CGO,
    S_CWAIT,
    S_MUL0,
    S_E2,
    S_L2LO,
    S_L2HI,
    S_L2SUM,
    S_ACC,
    S_NGO,
    S_NWAIT,
    S_OUT
  } state_e;

  state_e       state_q, state_d;
  logic [1:0]   mode_q, mode_d;
  logic [1:0]   idx_q, idx_d;
  logic [31:0]  mag_q [3];
  logic [31:0]  mag_d [3];
  logic [31:0]  area_q, area_d;
  logic         last_q, last_d;
  logic [65:0]  sum_q, sum_d;
  logic [63:0]  prod_q, prod_d;
  logic [63:0]  plo_q, plo_d;
  logic [95:0]  wide_q, wide_d;
  logic [31:0]  err_q, err_d;
  logic [63:0]  acc_q, acc_d;
  logic         sat_q, sat_d;
  out_item_t    out_q, out_d;
  logic         out_valid_q, out_valid_d;

  logic [31:0]  ref_c [3];
  logic [31:0]  est_c [3];
  logic [31:0]  mag_in [3];

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p;
  logic [63:0]  addend;
  logic [63:0]  add_sum;
  logic         add_ovf;

  logic              sqrt_start;
  logic              sqrt_done;
  logic [RAD_W-1:0]  sqrt_rad;
  logic [ROOT_W-1:0] sqrt_root;

  // Per-component magnitude of the difference, on the low CwEff bits sign-extended
  assign ref_c[0] = in_data_i.ref_x;
  assign ref_c[1] = in_data_i.ref_y;
  assign ref_c[2] = in_data_i.ref_z;
  assign est_c[0] = in_data_i.est_x;
  assign est_c[1] = in_data_i.est_y;
  assign est_c[2] = in_data_i.est_z;

  always_comb begin
    logic signed [32:0] ra, eb, dif;
    logic [32:0]        mag;
    for (int i = 0; i < 3; i++) begin
      ra  = $signed({{ExtW{ref_c[i][CwEff-1]}}, ref_c[i][CwEff-1:0]});
      eb  = $signed({{ExtW{est_c[i][CwEff-1]}}, est_c[i][CwEff-1:0]});
      dif = ra - eb;
      mag = dif[32] ? 33'(-dif) : 33'(dif);
      mag_in[i] = mag[31:0];
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQR: begin
        case (idx_q)
          2'd0:    begin mul_a = mag_q[0]; mul_b = mag_q[0]; end
          2'd1:    begin mul_a = mag_q[1]; mul_b = mag_q[1]; end
          2'd2:    begin mul_a = mag_q[2]; mul_b = mag_q[2]; end
          default: begin mul_a = '0;       mul_b = '0;       end
        endcase
      end
      S_MUL0:  begin mul_a = err_q;          mul_b = area_q; end
      S_E2:    begin mul_a = err_q;          mul_b = err_q;  end
      S_L2LO:  begin mul_a = prod_q[31:0];   mul_b = area_q; end
      S_L2HI:  begin mul_a = prod_q[63:32];  mul_b = area_q; end
      default: begin mul_a = '0;             mul_b = '0;     end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Accumulator term and saturating add
  assign addend  = (mode_q == MODE_L1) ? {16'b0, prod_q[63:16]} : {1'b0, wide_q[78:16]};
  assign add_sum = acc_q + addend;
  assign add_ovf = add_sum[63] || ((mode_q == MODE_L2) && (|wide_q[95:79]));

  // Root unit runs the cell root, then the final L2 root
  assign sqrt_start = (state_q == S_CGO) || (state_q == S_NGO);
  assign sqrt_rad   = (state_q == S_NGO) ? {2'b00, acc_q} : sum_q;

  wena_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    idx_d       = idx_q;
    mag_d       = mag_q;
    area_d      = area_q;
    last_d      = last_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    plo_d       = plo_q;
    wide_d      = wide_q;
    err_d       = err_q;
    acc_d       = acc_q;
    sat_d       = sat_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    // Take a configuration write
    if (cfg_valid_i) begin
      mode_d = cfg_data_i;
    end

    // Drop the output beat once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mag_d   = mag_in;
          area_d  = in_data_i.cell_area;
          last_d  = in_data_i.last_cell;
          sum_d   = '0;
          idx_d   = '0;
          state_d = S_SQR;
        end
      end
      S_SQR: begin
        // Square one component a cycle, add the previous square
        if (idx_q != 2'd3) begin
          prod_d = mul_p;
        end
        if (idx_q != 2'd0) begin
          sum_d = sum_q + {2'b00, prod_q};
        end
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          state_d = S_CGO;
        end
      end
      S_CGO: begin
        state_d = S_CWAIT;
      end
      S_CWAIT: begin
        if (sqrt_done) begin
          // Saturate the cell error to 32 bits
          if (sqrt_root[ROOT_W-1]) begin
            err_d = '1;
            sat_d = 1'b1;
          end else begin
            err_d = sqrt_root[31:0];
          end
          case (mode_q)
            MODE_L1: state_d = S_MUL0;
            MODE_L2: state_d = S_E2;
            default: state_d = S_ACC;
          endcase
        end
      end
      S_MUL0: begin
        prod_d  = mul_p;
        state_d = S_ACC;
      end
      S_E2: begin
        prod_d  = mul_p;
        state_d = S_L2LO;
      end
      S_L2LO: begin
        plo_d   = mul_p;
        state_d = S_L2HI;
      end
      S_L2HI: begin
        prod_d  = mul_p;
        state_d = S_L2SUM;
      end
      S_L2SUM: begin
        // Combine the two partial products of err^2 * area
        wide_d  = {prod_q, 32'b0} + {32'b0, plo_q};
        state_d = S_ACC;
      end
      S_ACC: begin
        case (mode_q)
          MODE_L1, MODE_L2: begin
            if (add_ovf) begin
              acc_d = ACC_MAX;
              sat_d = 1'b1;
            end else begin
              acc_d = add_sum;
            end
          end
          MODE_LINF: begin
            if ({32'b0, err_q} > acc_q) begin
              acc_d = {32'b0, err_q};
            end
          end
          default: begin
            acc_d = acc_q;
          end
        endcase
        if (last_q && (mode_q == MODE_L2)) begin
          state_d = S_NGO;
        end else begin
          state_d = S_OUT;
        end
      end
      S_NGO: begin
        state_d = S_NWAIT;
      end
      S_NWAIT: begin
        if (sqrt_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // Park the result once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d.cell_error = err_q;
          out_d.norm_ready = last_q;
          out_d.overflow   = sat_q;
          out_d.norm_value = '0;
          if (last_q) begin
            case (mode_q)
              MODE_L1, MODE_LINF: out_d.norm_value = acc_q[62:0];
              MODE_L2:            out_d.norm_value = {31'b0, sqrt_root[31:0]};
              default:            out_d.norm_value = '0;
            endcase
            acc_d = '0;
            sat_d = 1'b0;
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_RST;
      idx_q       <= '0;
      mag_q       <= '{default: '0};
      area_q      <= '0;
      last_q      <= 1'b0;
      sum_q       <= '0;
      prod_q      <= '0;
      plo_q       <= '0;
      wide_q      <= '0;
      err_q       <= '0;
      acc_q       <= '0;
      sat_q       <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      idx_q       <= idx_d;
      mag_q       <= mag_d;
      area_q      <= area_d;
      last_q      <= last_d;
      sum_q       <= sum_d;
      prod_q      <= prod_d;
      plo_q       <= plo_d;
      wide_q      <= wide_d;
      err_q       <= err_d;
      acc_q       <= acc_d;
      sat_q       <= sat_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // A beat without the norm carries a zero norm
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.norm_ready |-> out_data_o.norm_value == '0)
    else $error("norm_value set on a beat without norm_ready");

  // An accepted cell blocks the input on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after acceptance");

  // The root unit reports only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == S_CWAIT || state_q == S_NWAIT))
    else $error("root result outside a wait state");

  // The accumulator never passes its ceiling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc_q[63])
    else $error("accumulator above ceiling");

endmodule

@@ rtl/wena_sqrt.sv @@
// Iterative floor square root, one root bit per cycle.
`timescale 1ns / 1ps

module wena_sqrt
  import wena_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [REM_W-1:0]  rem_q, rem_d;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // Bring down the next two radicand bits and try the next root bit
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    rem_d  = rem_q;
    rad_d  = rad_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      rad_d  = rad_i;
      root_d = '0;
      cnt_d  = CNT_W'(ROOT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[RAD_W-3:0], 2'b00};
      if (fits) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      // Finish after the last root bit
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      rad_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      rad_q  <= rad_d;
      root_q <= root_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
